// File: hw/rtl/isx_pkg.sv
// Shared constants, codes and types of the interval set table.
package isx_pkg;

  localparam int MAX_INTERVALS = 64;
  localparam int VALUE_BITS    = 16;
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
  localparam int GROUP_SIZE    = 8;
  localparam int NUM_GROUPS    = (MAX_INTERVALS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int ACT_W         = 2;
  localparam int IN_W          = ((ACT_W + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_W         = ((VALUE_BITS + 3 + 7) / 8) * 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_ERASE    = 2'd1,
    ACT_CONTAINS = 2'd2,
    ACT_MEX      = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MERGE,
    OP_EXT_LOW_SIDE,
    OP_EXT_HIGH_SIDE,
    OP_NEW,
    OP_DROP,
    OP_TRIM_LO,
    OP_TRIM_HI,
    OP_SPLIT
  } op_t;

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic signed [VALUE_BITS:0]   wval_t;

  typedef struct packed {
    val_t  x;
    wval_t xm1;
    wval_t xp1;
  } probe_t;

  typedef struct packed {
    logic hit;
    logic lft;
    logic rgt;
    logic dlo;
    logic dhi;
    val_t high;
  } match_t;

endpackage

// File: hw/rtl/interval_set_mex_table_unit.sv
// Top level: sorted interval table as a chain of cells with a registered match tree.
// An input transaction passes the compare, group reduce and decide states before out_tvalid is registered.
// A new transaction is taken only in idle, after compare, group reduce, decide
// and the one-place shift of the cell chain; a stalled output holds the decide step.
// Reset (synchronous, rst_n low) empties the set at once; table entries are not cleared.
module interval_set_mex_table_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [isx_pkg::IN_W-1:0]  in_tdata,   // action[1:0], value[17:2], zero pad
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [isx_pkg::OUT_W-1:0] out_tdata   // success[0], mex_value[17:1], table_full[18], pad
);

  localparam int N  = isx_pkg::MAX_INTERVALS;
  localparam int VB = isx_pkg::VALUE_BITS;
  localparam int CW = isx_pkg::CNT_W;
  localparam int GS = isx_pkg::GROUP_SIZE;
  localparam int NG = isx_pkg::NUM_GROUPS;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_RED, S_DEC} state_t;

  state_t            state_r;
  isx_pkg::action_t  act_r;
  isx_pkg::val_t     x_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  isx_pkg::op_t      op_r;
  isx_pkg::op_t      op_nxt;
  isx_pkg::probe_t   probe;
  logic              out_tvalid_r;
  logic [isx_pkg::OUT_W-1:0] out_tdata_r;

  logic              valid_w [N];
  logic              le_w    [N];
  isx_pkg::val_t     low_w   [N];
  isx_pkg::val_t     high_w  [N];
  isx_pkg::match_t   match_w [N];
  isx_pkg::match_t   grp_r   [NG];
  isx_pkg::match_t   grp_nxt [NG];
  isx_pkg::match_t   tot;

  logic              success_nxt;
  logic              full_nxt;
  isx_pkg::wval_t    mex_nxt;
  logic              in_fire;
  logic              dec_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign dec_fire   = (state_r == S_DEC) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    probe.x   = x_r;
    probe.xm1 = isx_pkg::wval_t'({x_r[VB-1], x_r}) - isx_pkg::wval_t'(1);
    probe.xp1 = isx_pkg::wval_t'({x_r[VB-1], x_r}) + isx_pkg::wval_t'(1);
  end

  for (genvar j = 0; j < N; j++) begin : g_cell
    logic          le_dn;
    logic          le_up;
    isx_pkg::val_t low_dn;
    isx_pkg::val_t high_dn;
    isx_pkg::val_t low_up;
    isx_pkg::val_t high_up;

    assign valid_w[j] = count_r > (CW)'(j);

    if (j == 0) begin : g_first
      assign le_dn   = 1'b1;
      assign low_dn  = low_w[j];
      assign high_dn = high_w[j];
    end else begin : g_mid_dn
      assign le_dn   = le_w[j-1];
      assign low_dn  = low_w[j-1];
      assign high_dn = high_w[j-1];
    end

    if (j == N - 1) begin : g_last
      assign le_up   = 1'b0;
      assign low_up  = low_w[j];
      assign high_up = high_w[j];
    end else begin : g_mid_up
      assign le_up   = le_w[j+1];
      assign low_up  = low_w[j+1];
      assign high_up = high_w[j+1];
    end

    isx_cell u_cell (
      .clk     (clk),
      .cmp_en  (state_r == S_CMP),
      .valid   (valid_w[j]),
      .probe   (probe),
      .op      (op_r),
      .le_dn   (le_dn),
      .le_up   (le_up),
      .low_dn  (low_dn),
      .high_dn (high_dn),
      .low_up  (low_up),
      .high_up (high_up),
      .le_r    (le_w[j]),
      .low_r   (low_w[j]),
      .high_r  (high_w[j]),
      .match   (match_w[j])
    );
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < N) begin
          grp_nxt[g] = grp_nxt[g] | match_w[g * GS + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RED) begin
      for (int g = 0; g < NG; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_comb begin
    tot = '0;
    for (int g = 0; g < NG; g++) begin
      tot = tot | grp_r[g];
    end
  end

  always_comb begin
    op_nxt      = isx_pkg::OP_NONE;
    success_nxt = 1'b0;
    full_nxt    = 1'b0;
    mex_nxt     = '0;
    count_nxt   = count_r;
    unique case (act_r)
      isx_pkg::ACT_INSERT: begin
        if (!tot.hit) begin
          priority if (tot.lft && tot.rgt) begin
            op_nxt      = isx_pkg::OP_MERGE;
            success_nxt = 1'b1;
            count_nxt   = count_r - (CW)'(1);
          end else if (tot.lft) begin
            op_nxt      = isx_pkg::OP_EXT_LOW_SIDE;
            success_nxt = 1'b1;
          end else if (tot.rgt) begin
            op_nxt      = isx_pkg::OP_EXT_HIGH_SIDE;
            success_nxt = 1'b1;
          end else if (count_r >= (CW)'(N)) begin
            full_nxt    = 1'b1;
          end else begin
            op_nxt      = isx_pkg::OP_NEW;
            success_nxt = 1'b1;
            count_nxt   = count_r + (CW)'(1);
          end
        end
      end
      isx_pkg::ACT_ERASE: begin
        if (tot.hit) begin
          priority if (tot.dlo && tot.dhi) begin
            op_nxt      = isx_pkg::OP_DROP;
            success_nxt = 1'b1;
            count_nxt   = count_r - (CW)'(1);
          end else if (tot.dlo) begin
            op_nxt      = isx_pkg::OP_TRIM_LO;
            success_nxt = 1'b1;
          end else if (tot.dhi) begin
            op_nxt      = isx_pkg::OP_TRIM_HI;
            success_nxt = 1'b1;
          end else if (count_r >= (CW)'(N)) begin
            full_nxt    = 1'b1;
          end else begin
            op_nxt      = isx_pkg::OP_SPLIT;
            success_nxt = 1'b1;
            count_nxt   = count_r + (CW)'(1);
          end
        end
      end
      isx_pkg::ACT_CONTAINS: begin
        success_nxt = tot.hit;
      end
      isx_pkg::ACT_MEX: begin
        mex_nxt = tot.hit ?
                  isx_pkg::wval_t'({tot.high[VB-1], tot.high}) + isx_pkg::wval_t'(1) :
                  isx_pkg::wval_t'({x_r[VB-1], x_r});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      op_r         <= isx_pkg::OP_NONE;
      out_tvalid_r <= 1'b0;
    end else begin
      op_r         <= dec_fire ? op_nxt : isx_pkg::OP_NONE;
      out_tvalid_r <= dec_fire || (out_tvalid_r && !out_tready);
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_RED;
        end
        S_RED: begin
          state_r <= S_DEC;
        end
        S_DEC: begin
          if (dec_fire) begin
            state_r <= S_IDLE;
            count_r <= count_nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= isx_pkg::action_t'(in_tdata[isx_pkg::ACT_W-1:0]);
      x_r   <= in_tdata[isx_pkg::ACT_W+VB-1:isx_pkg::ACT_W];
    end
    if (dec_fire) begin
      out_tdata_r <= {{(isx_pkg::OUT_W-VB-3){1'b0}}, full_nxt, mex_nxt, success_nxt};
    end
  end

endmodule

// File: hw/rtl/isx_cell.sv
// One table cell: holds an interval, compares it with the probe, shifts with its neighbors.
module isx_cell (
  input  logic              clk,
  input  logic              cmp_en,
  input  logic              valid,
  input  isx_pkg::probe_t   probe,
  input  isx_pkg::op_t      op,
  input  logic              le_dn,
  input  logic              le_up,
  input  isx_pkg::val_t     low_dn,
  input  isx_pkg::val_t     high_dn,
  input  isx_pkg::val_t     low_up,
  input  isx_pkg::val_t     high_up,
  output logic              le_r,
  output isx_pkg::val_t     low_r,
  output isx_pkg::val_t     high_r,
  output isx_pkg::match_t   match
);

  logic          valid_r;
  logic          hi_ge_r;
  logic          hi_eqm1_r;
  logic          lo_eqp1_r;
  logic          lo_eq_r;
  logic          hi_eq_r;
  isx_pkg::val_t low_nxt;
  isx_pkg::val_t high_nxt;
  isx_pkg::wval_t low_w;
  isx_pkg::wval_t high_w;
  logic          pm1;
  logic          at_p;
  logic          above_p;
  logic          from_pm1;

  assign low_w  = isx_pkg::wval_t'({low_r[isx_pkg::VALUE_BITS-1], low_r});
  assign high_w = isx_pkg::wval_t'({high_r[isx_pkg::VALUE_BITS-1], high_r});

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      valid_r   <= valid;
      le_r      <= valid && ($signed(low_r) <= $signed(probe.x));
      hi_ge_r   <= $signed(high_r) >= $signed(probe.x);
      hi_eqm1_r <= high_w == probe.xm1;
      lo_eqp1_r <= low_w == probe.xp1;
      lo_eq_r   <= low_r == probe.x;
      hi_eq_r   <= high_r == probe.x;
    end
  end

  assign pm1      = le_r && !le_up;
  assign at_p     = !le_r && le_dn;
  assign above_p  = !le_dn;
  assign from_pm1 = !le_up;

  always_comb begin
    match.hit  = pm1 && hi_ge_r;
    match.lft  = pm1 && hi_eqm1_r;
    match.rgt  = valid_r && at_p && lo_eqp1_r;
    match.dlo  = pm1 && lo_eq_r;
    match.dhi  = pm1 && hi_eq_r;
    match.high = pm1 ? high_r : '0;
  end

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    unique case (op)
      isx_pkg::OP_MERGE: begin
        if (pm1) begin
          high_nxt = high_up;
        end else if (!le_r) begin
          low_nxt  = low_up;
          high_nxt = high_up;
        end
      end
      isx_pkg::OP_EXT_LOW_SIDE: begin
        if (pm1) high_nxt = probe.x;
      end
      isx_pkg::OP_EXT_HIGH_SIDE: begin
        if (at_p) low_nxt = probe.x;
      end
      isx_pkg::OP_NEW: begin
        if (above_p) begin
          low_nxt  = low_dn;
          high_nxt = high_dn;
        end else if (at_p) begin
          low_nxt  = probe.x;
          high_nxt = probe.x;
        end
      end
      isx_pkg::OP_DROP: begin
        if (from_pm1) begin
          low_nxt  = low_up;
          high_nxt = high_up;
        end
      end
      isx_pkg::OP_TRIM_LO: begin
        if (pm1) low_nxt = probe.xp1[isx_pkg::VALUE_BITS-1:0];
      end
      isx_pkg::OP_TRIM_HI: begin
        if (pm1) high_nxt = probe.xm1[isx_pkg::VALUE_BITS-1:0];
      end
      isx_pkg::OP_SPLIT: begin
        if (pm1) begin
          high_nxt = probe.xm1[isx_pkg::VALUE_BITS-1:0];
        end else if (above_p) begin
          low_nxt  = low_dn;
          high_nxt = high_dn;
        end else if (at_p) begin
          low_nxt  = probe.xp1[isx_pkg::VALUE_BITS-1:0];
          high_nxt = high_dn;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    high_r <= high_nxt;
  end

endmodule

// File: hw/rtl/isx_checker.sv
// Port-level checks of the interval set table, bound to the top level.
module isx_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [isx_pkg::OUT_W-1:0] out_tdata
);

  localparam int VB = isx_pkg::VALUE_BITS;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[VB+2]))
    else $error("success and table_full both set");

  a_mex_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[VB+1:1] != '0) |-> !out_tdata[0] && !out_tdata[VB+2])
    else $error("mex result carries success or table_full");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("input accepted while a transaction is in flight");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind interval_set_mex_table_unit isx_checker u_isx_checker (.*);

// File: dv/isx_check_pkg.sv
// Scoreboard for the interval set table: behavioral prediction and result comparison.
package isx_check_pkg;
  import isx_pkg::*;

  typedef struct {
    bit    success;
    wval_t mex_value;
    bit    table_full;
  } set_reply_t;

  class interval_set_scoreboard;
    int lo_end[MAX_INTERVALS];
    int hi_end[MAX_INTERVALS];
    int n_spans;
    set_reply_t expected_replies[$];
    int errors;
    int replies;
    int n_merge;
    int n_split;
    int n_mex;
    int n_full;

    function void open_span(int at);
      for (int i = n_spans; i > at; i--) begin
        lo_end[i] = lo_end[i-1];
        hi_end[i] = hi_end[i-1];
      end
      n_spans++;
    endfunction

    function void remove_span(int at);
      for (int i = at; i + 1 < n_spans; i++) begin
        lo_end[i] = lo_end[i+1];
        hi_end[i] = hi_end[i+1];
      end
      n_spans--;
    endfunction

    function void apply_request(action_t act, val_t v);
      int x;
      int pos;
      int lo;
      int hi;
      bit present;
      bit joins_left;
      bit joins_right;
      set_reply_t r;
      x = int'(v);
      r.success = 1'b0;
      r.mex_value = '0;
      r.table_full = 1'b0;
      pos = 0;
      while (pos < n_spans && lo_end[pos] <= x) pos++;
      present = (pos > 0) && (hi_end[pos-1] >= x);
      case (act)
        ACT_INSERT: begin
          if (!present) begin
            joins_left = (pos > 0) && (hi_end[pos-1] == x - 1);
            joins_right = (pos < n_spans) && (lo_end[pos] == x + 1);
            if (joins_left && joins_right) begin
              hi_end[pos-1] = hi_end[pos];
              remove_span(pos);
              n_merge++;
              r.success = 1'b1;
            end else if (joins_left) begin
              hi_end[pos-1] = x;
              r.success = 1'b1;
            end else if (joins_right) begin
              lo_end[pos] = x;
              r.success = 1'b1;
            end else if (n_spans >= MAX_INTERVALS) begin
              r.table_full = 1'b1;
              n_full++;
            end else begin
              open_span(pos);
              lo_end[pos] = x;
              hi_end[pos] = x;
              r.success = 1'b1;
            end
          end
        end
        ACT_ERASE: begin
          if (present) begin
            lo = lo_end[pos-1];
            hi = hi_end[pos-1];
            if (x == lo && x == hi) begin
              remove_span(pos - 1);
              r.success = 1'b1;
            end else if (x == lo) begin
              lo_end[pos-1] = x + 1;
              r.success = 1'b1;
            end else if (x == hi) begin
              hi_end[pos-1] = x - 1;
              r.success = 1'b1;
            end else if (n_spans >= MAX_INTERVALS) begin
              r.table_full = 1'b1;
              n_full++;
            end else begin
              open_span(pos);
              hi_end[pos-1] = x - 1;
              lo_end[pos] = x + 1;
              hi_end[pos] = hi;
              n_split++;
              r.success = 1'b1;
            end
          end
        end
        ACT_CONTAINS: begin
          r.success = present;
        end
        default: begin
          r.mex_value = wval_t'(present ? hi_end[pos-1] + 1 : x);
          n_mex++;
        end
      endcase
      expected_replies.push_back(r);
    endfunction

    function void compare_reply(logic success, wval_t mex_value, logic table_full);
      set_reply_t e;
      if (expected_replies.size() == 0) begin
        $error("unexpected result transaction: success=%0d mex_value=%0d table_full=%0d",
               success, mex_value, table_full);
        errors++;
        return;
      end
      e = expected_replies.pop_front();
      replies++;
      if (success !== e.success) begin
        $error("success mismatch: expected %0d, got %0d", e.success, success);
        errors++;
      end
      if (mex_value !== e.mex_value) begin
        $error("mex_value mismatch: expected %0d, got %0d", e.mex_value, mex_value);
        errors++;
      end
      if (table_full !== e.table_full) begin
        $error("table_full mismatch: expected %0d, got %0d", e.table_full, table_full);
        errors++;
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

endpackage

// File: dv/tb_top.sv
// Testbench top for the interval set table with mex queries.
module tb_top;
  import isx_pkg::*;
  import isx_check_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  interval_set_scoreboard sb = new;

  int burst_left = 0;
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_pct = 0;
  int mode_left = 0;
  int cycles = 0;

  interval_set_mex_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.apply_request(action_t'(in_tdata[ACT_W-1:0]), val_t'(in_tdata[ACT_W+VALUE_BITS-1:ACT_W]));
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.compare_reply(out_tdata[0], wval_t'(out_tdata[VALUE_BITS+1:1]),
                       out_tdata[VALUE_BITS+2]);
    end
  end

  always @(posedge clk) begin
    if (holds_served != holds_asked) begin
      holds_served = holds_asked;
      hold_left = 120;
    end
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 200);
      stall_pct = 30 * $urandom_range(0, 3);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("interval_set_mex_table_unit test failed");
      $finish;
    end
  end

  task automatic push_item(action_t a, val_t v);
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_W-ACT_W-VALUE_BITS){1'b0}}, v, a};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic hold_input(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic offer(action_t a, val_t v);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) hold_input($urandom_range(1, 10));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    push_item(a, v);
  endtask

  function automatic action_t pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return ACT_INSERT;
    if (r < 60) return ACT_ERASE;
    if (r < 75) return ACT_CONTAINS;
    return ACT_MEX;
  endfunction

  task automatic wait_for_replies();
    hold_input(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // erase the lowest element until the set is empty
  task automatic empty_set();
    while (1) begin
      hold_input(1);
      if (sb.n_spans == 0) break;
      push_item(ACT_ERASE, val_t'(sb.lo_end[0]));
    end
  endtask

  task automatic run_random(int target);
    int sent;
    int len;
    int width;
    int base;
    int x;
    sent = 0;
    while (sent < target) begin
      len = $urandom_range(10, 50);
      width = $urandom_range(4, 120);
      case ($urandom_range(0, 7))
        0: base = -32768;
        1: base = 32767 - width;
        default: base = int'($urandom_range(0, 65535 - width)) - 32768;
      endcase
      for (int i = 0; i < len && sent < target; i++) begin
        if ($urandom_range(0, 9) == 0) x = int'($urandom_range(0, 65535)) - 32768;
        else x = base + int'($urandom_range(0, width));
        offer(pick_action(), val_t'(x));
        sent++;
      end
    end
  endtask

  initial begin
    int base;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(ACT_MEX, -16'sd5);
    offer(ACT_CONTAINS, 16'sd0);
    offer(ACT_ERASE, 16'sd7);
    offer(ACT_INSERT, -16'sd32768);
    offer(ACT_MEX, -16'sd32768);
    offer(ACT_INSERT, 16'sd32767);
    offer(ACT_MEX, 16'sd32767);
    offer(ACT_INSERT, 16'sd32767);
    offer(ACT_INSERT, 16'sd10);
    offer(ACT_INSERT, 16'sd12);
    offer(ACT_INSERT, 16'sd11);
    offer(ACT_INSERT, 16'sd9);
    offer(ACT_INSERT, 16'sd13);
    offer(ACT_CONTAINS, 16'sd11);
    offer(ACT_MEX, 16'sd9);
    offer(ACT_MEX, 16'sd14);
    offer(ACT_ERASE, 16'sd11);
    offer(ACT_ERASE, 16'sd9);
    offer(ACT_ERASE, 16'sd13);
    offer(ACT_ERASE, 16'sd10);
    offer(ACT_ERASE, 16'sd12);
    offer(ACT_INSERT, -16'sd32767);
    offer(ACT_ERASE, -16'sd32768);
    offer(ACT_ERASE, 16'sd32767);
    offer(ACT_CONTAINS, -16'sd1);
    wait_for_replies();

    holds_asked++;
    run_random(180);
    empty_set();

    base = int'($urandom_range(0, 65235)) - 32768;
    for (int k = 0; k < MAX_INTERVALS; k++) offer(ACT_INSERT, val_t'(base + 2 * k));
    offer(ACT_INSERT, val_t'(base + 200));
    offer(ACT_INSERT, val_t'(base + 1));
    offer(ACT_INSERT, val_t'(base + 200));
    offer(ACT_ERASE, val_t'(base + 1));
    offer(ACT_CONTAINS, val_t'(base + 1));
    offer(ACT_MEX, val_t'(base));
    for (int k = 0; k < 40; k++) begin
      offer(pick_action(), val_t'(base + int'($urandom_range(0, 210))));
    end
    wait_for_replies();
    empty_set();

    holds_asked++;
    run_random(180);
    wait_for_replies();

    $display("Covered %0d transactions: %0d merges, %0d splits, %0d mex queries,",
             sb.replies, sb.n_merge, sb.n_split, sb.n_mex);
    $display("and %0d refusals on a full table, with idles and stalls on both sides.",
             sb.n_full);
    if (sb.errors == 0) begin
      $display("interval_set_mex_table_unit test passed");
    end else begin
      $display("interval_set_mex_table_unit test failed");
    end
    $finish;
  end

endmodule
